// ===== src/pcmrs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and register codes of the PCM linear resampler.
// Used by every module of the block; depends on nothing.
package pcmrs_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int FRAC_BITS   = 8;
    localparam int POS_BITS    = COUNT_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS   = 12;
    localparam int SAMPLE_BITS = 16;
    localparam int BYTE_BITS   = 8;

    // Steps below one eighth of a source sample are raised to that minimum.
    localparam logic [STEP_BITS-1:0] MIN_STEP = STEP_BITS'(1 << (FRAC_BITS - 3));
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1 << FRAC_BITS);

    localparam int MAX_RESULTS = 16;
    localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = COUNT_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STEP_FIXED   = 2'd0,
        CFG_WIDE_INPUT   = 2'd1,
        CFG_OUTPUT_TOTAL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [STEP_BITS-1:0]  step_fixed;
        logic                  wide_input;
        logic [COUNT_BITS-1:0] output_total;
    } t_cfg;

    // One queued source sample, already widened to signed 16 bits.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_in;
    } t_item;

endpackage

// ===== src/pcmrs_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the PCM linear resampler: one source sample per beat.
// Depends on pcmrs_pkg for field widths.
interface pcmrs_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [pcmrs_pkg::SAMPLE_BITS-1:0]     raw_sample;
    logic                                  final_input;

    modport source (output valid, output raw_sample, output final_input, input ready);
    modport sink   (input valid, input raw_sample, input final_input, output ready);
endinterface

// ===== src/pcmrs_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the PCM linear resampler: one interpolated sample per beat.
// Depends on pcmrs_pkg for field widths.
interface pcmrs_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pcmrs_pkg::SAMPLE_BITS-1:0] out_sample;
    logic                                  run_end;
    logic                                  sound_done;

    modport source (output valid, output out_sample, output run_end, output sound_done,
                    input ready);
    modport sink   (input valid, input out_sample, input run_end, input sound_done,
                    output ready);
endinterface

// ===== src/pcmrs_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts source beats, widens 8-bit unsigned samples to signed 16
// and pushes them into the item queue. Depends on pcmrs_pkg and pcmrs_in_if.
module pcmrs_front (
    pcmrs_in_if.sink          i_in,
    input  logic              i_wide,
    input  logic              i_full,
    output logic              o_push,
    output pcmrs_pkg::t_item  o_item
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // (byte - 128) << 8 is the byte with its top bit inverted, moved to the high half.
    always_comb begin
        if (i_wide) begin
            o_item.sample = $signed(i_in.raw_sample);
        end else begin
            o_item.sample = $signed({~i_in.raw_sample[pcmrs_pkg::BYTE_BITS-1],
                                     i_in.raw_sample[pcmrs_pkg::BYTE_BITS-2:0],
                                     {pcmrs_pkg::BYTE_BITS{1'b0}}});
        end
        o_item.final_in = i_in.final_input;
    end

endmodule

// ===== src/pcmrs_queue.sv =====
`timescale 1ns / 1ps
// Short item queue between the front end and the interpolation engine.
// Depends on pcmrs_pkg for the item type and depth.
module pcmrs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcmrs_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output pcmrs_pkg::t_item  o_item
);

    localparam int CNT_BITS = $clog2(pcmrs_pkg::QUEUE_DEPTH + 1);

    pcmrs_pkg::t_item r_mem [pcmrs_pkg::QUEUE_DEPTH];
    logic [pcmrs_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [pcmrs_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]            r_count, n_count;
    logic                           do_pop;

    assign o_full  = (r_count == CNT_BITS'(pcmrs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [pcmrs_pkg::QUEUE_AW-1:0] f_next(
        input logic [pcmrs_pkg::QUEUE_AW-1:0] ptr
    );
        if (ptr == pcmrs_pkg::QUEUE_AW'(pcmrs_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? f_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? f_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/pcmrs_engine.sv =====
`timescale 1ns / 1ps
// Interpolation engine: walks the read position across each queued sample, one result
// per cycle while the output register is free. Depends on pcmrs_pkg, pcmrs_out_if.
module pcmrs_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcmrs_pkg::t_cfg   i_cfg,
    input  logic              i_q_valid,
    input  pcmrs_pkg::t_item  i_q_item,
    output logic              o_q_pop,
    pcmrs_out_if.source       o_out
);

    localparam int CB = pcmrs_pkg::COUNT_BITS;
    localparam int FB = pcmrs_pkg::FRAC_BITS;
    localparam int PB = pcmrs_pkg::POS_BITS;
    localparam int SB = pcmrs_pkg::SAMPLE_BITS;
    localparam int NB = pcmrs_pkg::NRES_BITS;
    localparam int DB = SB + 1;
    localparam int MB = DB + FB + 1;

    logic signed [SB-1:0] r_prev, n_prev;
    logic [PB-1:0]        r_pos, n_pos;
    logic [CB-1:0]        r_index, n_index;
    logic [CB-1:0]        r_made, n_made;
    logic [NB-1:0]        r_nres, n_nres;

    logic                 r_out_valid, n_out_valid;
    logic signed [SB-1:0] r_out_sample, n_out_sample;
    logic                 r_out_run_end, n_out_run_end;
    logic                 r_out_done, n_out_done;

    logic [pcmrs_pkg::STEP_BITS-1:0] step_eff;
    logic [CB-1:0]        pos_int, prev_k, new_int, new_made;
    logic [PB-1:0]        new_pos;
    logic [FB-1:0]        frac;
    logic                 cond_a, cond_b, want, out_free, emit, cont, finish;
    logic signed [SB-1:0] s0, s1, blend;
    logic signed [DB-1:0] diff;
    logic signed [MB-1:0] prod;
    logic signed [MB-1:0] shifted;

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        step_eff = (i_cfg.step_fixed < pcmrs_pkg::MIN_STEP) ? pcmrs_pkg::MIN_STEP
                                                             : i_cfg.step_fixed;
        pos_int  = r_pos[FB +: CB];
        frac     = r_pos[FB-1:0];
        prev_k   = r_index - 1'b1;
        new_pos  = r_pos + PB'(step_eff);
        new_int  = new_pos[FB +: CB];
        new_made = r_made + 1'b1;

        // Position in the interval ending at this sample, or past it on the last sample.
        cond_a = (r_index != '0) && (pos_int == prev_k);
        cond_b = i_q_item.final_in && (pos_int == r_index);
        want   = i_q_valid && (r_nres < NB'(pcmrs_pkg::MAX_RESULTS))
                 && (r_made < i_cfg.output_total) && (cond_a || cond_b);
        emit   = want && out_free;

        // Look ahead one step to tell whether this result closes the item.
        cont = ((r_nres + 1'b1) < NB'(pcmrs_pkg::MAX_RESULTS))
               && (new_made < i_cfg.output_total)
               && ((cond_a && (new_int == prev_k))
                   || (i_q_item.final_in && (new_int == r_index)));

        finish = (emit && !cont) || (i_q_valid && !want);

        s1      = i_q_item.sample;
        s0      = cond_a ? r_prev : i_q_item.sample;
        diff    = DB'(s1) - DB'(s0);
        prod    = MB'(diff) * $signed({1'b0, frac});
        shifted = prod >>> FB;
        blend   = s0 + shifted[SB-1:0];

        n_prev  = r_prev;
        n_pos   = r_pos;
        n_index = r_index;
        n_made  = r_made;
        n_nres  = r_nres;

        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_sample  = r_out_sample;
        n_out_run_end = r_out_run_end;
        n_out_done    = r_out_done;

        if (emit) begin
            n_pos         = new_pos;
            n_made        = new_made;
            n_nres        = r_nres + 1'b1;
            n_out_valid   = 1'b1;
            n_out_sample  = blend;
            n_out_run_end = !cont;
            n_out_done    = (new_made == i_cfg.output_total);
        end

        if (finish) begin
            n_nres = '0;
            if (i_q_item.final_in) begin
                n_prev  = '0;
                n_pos   = '0;
                n_index = '0;
                n_made  = '0;
            end else begin
                n_prev  = i_q_item.sample;
                n_index = r_index + 1'b1;
            end
        end
    end

    assign o_q_pop = finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_pos       <= '0;
            r_index     <= '0;
            r_made      <= '0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_pos       <= n_pos;
            r_index     <= n_index;
            r_made      <= n_made;
            r_nres      <= n_nres;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sample  <= n_out_sample;
        r_out_run_end <= n_out_run_end;
        r_out_done    <= n_out_done;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_sample;
    assign o_out.run_end    = r_out_run_end;
    assign o_out.sound_done = r_out_done;

endmodule

// ===== src/pcm_linear_resampler_unit.sv =====
`timescale 1ns / 1ps
// Top level of the PCM linear resampler: configuration registers, front end,
// item queue and interpolation engine. Depends on pcmrs_pkg and both channel interfaces.
//
// Each source beat is widened to signed 16 bits and queued; the engine then produces
// one interpolated sample per cycle, while the output register is free, for every
// output position that falls between the previous and the current source sample (at
// most sixteen per beat); a beat that yields no result is popped without output. The
// two-entry queue and the output register let input beats arrive while results are
// still being taken. The engine's one-result-per-cycle loop sets the rate. Configuration
// must be written only while the block is idle; the block itself does not enforce this.
module pcm_linear_resampler_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [pcmrs_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [pcmrs_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    pcmrs_in_if.sink                                 i_in,
    pcmrs_out_if.source                              o_out
);

    pcmrs_pkg::t_cfg  r_cfg, n_cfg;
    pcmrs_pkg::t_item front_item, q_item;
    logic             push, full, pop, q_valid;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (pcmrs_pkg::t_cfg_idx'(i_cfg_index))
                pcmrs_pkg::CFG_STEP_FIXED: begin
                    n_cfg.step_fixed = i_cfg_data[pcmrs_pkg::STEP_BITS-1:0];
                end
                pcmrs_pkg::CFG_WIDE_INPUT: begin
                    n_cfg.wide_input = i_cfg_data[0];
                end
                pcmrs_pkg::CFG_OUTPUT_TOTAL: begin
                    n_cfg.output_total = i_cfg_data[pcmrs_pkg::COUNT_BITS-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_fixed   <= pcmrs_pkg::STEP_RESET;
            r_cfg.wide_input   <= 1'b0;
            r_cfg.output_total <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pcmrs_front u_front (
        .i_in   (i_in),
        .i_wide (r_cfg.wide_input),
        .i_full (full),
        .o_push (push),
        .o_item (front_item)
    );

    pcmrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pcmrs_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pcm_linear_resampler_unit: a directed script, then random sounds
// under four pacing modes, with every output beat checked by an in-bench interpolation model or a typed-in result.
// Depends on pcmrs_pkg, pcmrs_in_if, pcmrs_out_if and the block itself.
module tb;
    import pcmrs_pkg::*;

    localparam int RAND_ITEMS  = 450;
    localparam int SHOW_ERRORS = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;

    typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} t_pace;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          run_end;
        logic                          done;
    } t_pcm_out;

    // One script line: either a register write or a source sample. A sample line with
    // known_n >= 0 carries its result typed in; otherwise the model supplies it.
    typedef struct {
        bit                            is_cfg;
        t_cfg_idx                      reg_sel;
        logic [CFG_DATA_BITS-1:0]      data;
        logic [SAMPLE_BITS-1:0]        raw;
        logic                          fin;
        int                            known_n;
        logic signed [SAMPLE_BITS-1:0] known_sample;
        logic                          known_done;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    pcmrs_in_if  in_ch();
    pcmrs_out_if out_ch();

    pcm_linear_resampler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // Interpolator model: registers and running state.
    logic [STEP_BITS-1:0]          r_step;
    logic                          r_wide;
    logic [COUNT_BITS-1:0]         r_total;
    logic signed [SAMPLE_BITS-1:0] m_prev;
    logic [POS_BITS-1:0]           m_pos;
    logic [COUNT_BITS-1:0]         m_idx;
    logic [COUNT_BITS-1:0]         m_made;

    t_pcm_out fresh[$];
    t_pcm_out pending_out[$];
    t_row     script[$];

    t_pace pace;
    logic  hold_ask;
    logic  hold_taken = 1'b0;
    int    hold_left = 0;

    int n_errors = 0;
    int n_checked = 0;
    int n_samples;
    int n_sounds;
    int n_writes;

    function automatic int idle_pct(bit on_send);
        case (pace)
            PACE_SEND_IDLE:  return on_send ? 77 : 0;
            PACE_RECV_STALL: return on_send ? 0 : 77;
            PACE_BOTH:       return 35;
            default:         return 0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] mix(logic signed [SAMPLE_BITS-1:0] s0,
                                                           logic signed [SAMPLE_BITS-1:0] s1,
                                                           logic [FRAC_BITS-1:0] frac);
        int p;
        p = (int'(s1) - int'(s0)) * int'({1'b0, frac});
        // The arithmetic shift floors toward minus infinity, also for a falling slope.
        return SAMPLE_BITS'(int'(s0) + (p >>> FRAC_BITS));
    endfunction

    function automatic void emit_point(logic signed [SAMPLE_BITS-1:0] s0,
                                       logic signed [SAMPLE_BITS-1:0] s1);
        logic [STEP_BITS-1:0] stride;
        t_pcm_out r;
        stride = (r_step < MIN_STEP) ? MIN_STEP : r_step;
        r.sample = mix(s0, s1, m_pos[FRAC_BITS-1:0]);
        m_made = m_made + 1'b1;
        r.run_end = 1'b0;
        r.done = (m_made == r_total);
        fresh.push_back(r);
        m_pos = m_pos + stride;
    endfunction

    function automatic void forecast(logic [SAMPLE_BITS-1:0] raw, logic fin);
        logic signed [SAMPLE_BITS-1:0] x;
        logic [COUNT_BITS-1:0] k;
        x = r_wide ? raw : {raw[BYTE_BITS-1:0] ^ 8'h80, 8'h00};
        k = m_idx;
        fresh.delete();
        if (k != 0) begin
            while (fresh.size() < MAX_RESULTS && m_made < r_total &&
                   m_pos[FRAC_BITS +: COUNT_BITS] == k - 1'b1)
                emit_point(m_prev, x);
        end
        // On the last sample of a sound the remaining positions hold the sample flat.
        if (fin) begin
            while (fresh.size() < MAX_RESULTS && m_made < r_total &&
                   m_pos[FRAC_BITS +: COUNT_BITS] == k)
                emit_point(x, x);
        end
        if (fresh.size() != 0)
            fresh[fresh.size() - 1].run_end = 1'b1;
        if (fin) begin
            m_prev = '0;
            m_pos = '0;
            m_idx = '0;
            m_made = '0;
        end else begin
            m_prev = x;
            m_idx = k + 1'b1;
        end
    endfunction

    function automatic t_row reg_row(t_cfg_idx sel, logic [CFG_DATA_BITS-1:0] value);
        t_row r;
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.data = value;
        r.raw = '0;
        r.fin = 1'b0;
        r.known_n = -1;
        r.known_sample = '0;
        r.known_done = 1'b0;
        return r;
    endfunction

    function automatic t_row sample_row(logic [SAMPLE_BITS-1:0] raw, logic fin);
        t_row r;
        r = reg_row(CFG_STEP_FIXED, '0);
        r.is_cfg = 1'b0;
        r.raw = raw;
        r.fin = fin;
        return r;
    endfunction

    function automatic t_row known_row(logic [SAMPLE_BITS-1:0] raw, logic fin, int n,
                                       logic signed [SAMPLE_BITS-1:0] s, logic done);
        t_row r;
        r = sample_row(raw, fin);
        r.known_n = n;
        r.known_sample = s;
        r.known_done = done;
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx sel, logic [CFG_DATA_BITS-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= value;
        case (sel)
            CFG_STEP_FIXED:   r_step = value[STEP_BITS-1:0];
            CFG_WIDE_INPUT:   r_wide = value[0];
            CFG_OUTPUT_TOTAL: r_total = value;
            default: ;
        endcase
        n_writes++;
        @(posedge i_clk);
    endtask

    // Lets every expected beat come out, then waits further for beats that yield nothing.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic feed_sample(t_row r);
        t_pcm_out t;
        while ($urandom_range(0, 99) < idle_pct(1'b1)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_sample <= r.raw;
        in_ch.final_input <= r.fin;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        n_samples++;
        forecast(r.raw, r.fin);
        if (r.known_n >= 0) begin
            fresh.delete();
            if (r.known_n == 1) begin
                t.sample = r.known_sample;
                t.run_end = 1'b1;
                t.done = r.known_done;
                fresh.push_back(t);
            end
        end
        foreach (fresh[j])
            pending_out.push_back(fresh[j]);
    endtask

    // Receiver: random stalls per pacing mode, plus one long hold on request.
    always @(posedge i_clk) begin
        if (hold_ask && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
        end
    end

    always @(posedge i_clk) begin
        t_pcm_out e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_checked++;
            if (pending_out.size() == 0) begin
                n_errors++;
                if (n_errors <= SHOW_ERRORS)
                    $display("ERROR: unexpected output beat: sample %0d run_end %b done %b",
                             out_ch.out_sample, out_ch.run_end, out_ch.sound_done);
            end else begin
                e = pending_out.pop_front();
                if (out_ch.out_sample !== e.sample || out_ch.run_end !== e.run_end ||
                    out_ch.sound_done !== e.done) begin
                    n_errors++;
                    if (n_errors <= SHOW_ERRORS)
                        $display("ERROR: beat %0d: expected sample %0d run_end %b done %b, got %0d %b %b",
                                 n_checked, e.sample, e.run_end, e.done,
                                 out_ch.out_sample, out_ch.run_end, out_ch.sound_done);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int rnd_items;
        int len;
        bit pressed;
        logic [STEP_BITS-1:0] step;
        logic [COUNT_BITS-1:0] total;
        logic wide;
        logic last_fin;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_STEP_FIXED;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.raw_sample <= '0;
        in_ch.final_input <= 1'b0;
        pace <= PACE_FULL;
        hold_ask <= 1'b0;
        n_samples = 0;
        n_sounds = 0;
        n_writes = 0;
        r_step = STEP_RESET;
        r_wide = 1'b0;
        r_total = '0;
        m_prev = '0;
        m_pos = '0;
        m_idx = '0;
        m_made = '0;

        // Reset defaults: a zero output count lets nothing through.
        script.push_back(known_row(16'h00FF, 1'b0, 0, 16'sd0, 1'b0));
        script.push_back(known_row(16'h0000, 1'b1, 0, 16'sd0, 1'b0));
        // 8-bit mode at unit step: the first sample gives nothing, then s0 at fraction zero.
        script.push_back(reg_row(CFG_OUTPUT_TOTAL, 24'd100));
        script.push_back(known_row(16'hFF00, 1'b0, 0, 16'sd0, 1'b0));
        script.push_back(known_row(16'h00FF, 1'b0, 1, 16'sh8000, 1'b0));
        script.push_back(known_row(16'h0080, 1'b0, 1, 16'sd32512, 1'b0));
        script.push_back(sample_row(16'h0001, 1'b1));
        // 16-bit mode, quarter step, full-scale swings.
        script.push_back(reg_row(CFG_STEP_FIXED, 24'd64));
        script.push_back(reg_row(CFG_WIDE_INPUT, 24'd1));
        script.push_back(known_row(16'h8000, 1'b0, 0, 16'sd0, 1'b0));
        script.push_back(sample_row(16'h7FFF, 1'b0));
        script.push_back(sample_row(16'hFFFF, 1'b0));
        script.push_back(sample_row(16'h0001, 1'b1));
        // A zero step is raised to one eighth, so the final sample yields sixteen beats.
        script.push_back(reg_row(CFG_STEP_FIXED, 24'd0));
        script.push_back(sample_row(16'h7FFF, 1'b0));
        script.push_back(sample_row(16'h8000, 1'b1));
        // Largest step: intervals without a position, sound ends with no done mark.
        script.push_back(reg_row(CFG_STEP_FIXED, 24'd4095));
        script.push_back(sample_row(16'h1234, 1'b0));
        script.push_back(sample_row(16'h5678, 1'b0));
        script.push_back(sample_row(16'h9ABC, 1'b0));
        script.push_back(sample_row(16'hDEF0, 1'b0));
        script.push_back(sample_row(16'h0F0F, 1'b1));
        // Output count reached after three beats; later samples give nothing.
        script.push_back(reg_row(CFG_STEP_FIXED, 24'd256));
        script.push_back(reg_row(CFG_WIDE_INPUT, 24'd0));
        script.push_back(reg_row(CFG_OUTPUT_TOTAL, 24'd3));
        script.push_back(sample_row(16'h0010, 1'b0));
        script.push_back(sample_row(16'h0020, 1'b0));
        script.push_back(sample_row(16'h0030, 1'b0));
        script.push_back(sample_row(16'h0040, 1'b0));
        script.push_back(sample_row(16'h0050, 1'b1));
        // Count lowered below what the sound already produced.
        script.push_back(reg_row(CFG_STEP_FIXED, 24'd128));
        script.push_back(reg_row(CFG_OUTPUT_TOTAL, 24'd10));
        script.push_back(sample_row(16'h0055, 1'b0));
        script.push_back(sample_row(16'h00AA, 1'b0));
        script.push_back(reg_row(CFG_OUTPUT_TOTAL, 24'd1));
        script.push_back(known_row(16'h00CC, 1'b0, 0, 16'sd0, 1'b0));
        script.push_back(known_row(16'h0033, 1'b1, 0, 16'sd0, 1'b0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain_block();
                write_reg(script[i].reg_sel, script[i].data);
                i_cfg_we <= 1'b0;
            end else begin
                feed_sample(script[i]);
            end
        end

        rnd_items = 0;
        pressed = 1'b0;
        last_fin = 1'b1;
        while (rnd_items < RAND_ITEMS) begin
            pace <= t_pace'(rnd_items * 4 / RAND_ITEMS);
            drain_block();
            case ($urandom_range(0, 9))
                0:       step = 12'd32;
                1:       step = 12'd2048;
                2:       step = STEP_BITS'($urandom_range(0, 31));
                3:       step = STEP_BITS'($urandom_range(2049, 4095));
                default: step = STEP_BITS'($urandom_range(32, 512));
            endcase
            case ($urandom_range(0, 15))
                0:       total = '0;
                1:       total = 24'hFFFFFF;
                2, 3:    total = COUNT_BITS'($urandom_range(1, 6));
                default: total = COUNT_BITS'($urandom_range(7, 400));
            endcase
            wide = 1'($urandom_range(0, 1));
            len = $urandom_range(1, 24);
            // Once, early and unpaced: many beats per sample against a long output hold.
            if (!pressed && rnd_items >= 40) begin
                step = MIN_STEP;
                total = 24'hFFFFFF;
                wide = 1'b1;
                len = 24;
            end
            write_reg(CFG_STEP_FIXED, CFG_DATA_BITS'(step));
            write_reg(CFG_WIDE_INPUT, CFG_DATA_BITS'(wide));
            write_reg(CFG_OUTPUT_TOTAL, total);
            i_cfg_we <= 1'b0;
            if (!pressed && rnd_items >= 40) begin
                hold_ask <= 1'b1;
                pressed = 1'b1;
            end
            if (last_fin)
                n_sounds++;
            // Most sounds close with a final sample; a few run on into the next settings.
            last_fin = ($urandom_range(0, 9) != 0);
            for (int j = 0; j < len; j++) begin
                feed_sample(sample_row(SAMPLE_BITS'($urandom_range(0, 65535)),
                                       last_fin && j == len - 1));
                rnd_items++;
            end
        end

        drain_block();
        repeat (2 * DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d source samples in about %0d sounds under four pacing modes,",
                 n_samples, n_sounds);
        $display("one long output hold included; %0d beats checked, %0d register writes, %0d errors.",
                 n_checked, n_writes, n_errors);
        if (n_errors == 0 && pending_out.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
